### hdl/qslerp_pkg.sv
// shared types, constants and the arctangent table of the quaternion slerp block
package qslerp_pkg;

    // component format is signed Q2.14
    localparam int COMP_BITS    = 16;
    localparam int FRAC_BITS    = COMP_BITS - 2;
    localparam int BLEND_BITS   = 17;
    localparam int CORDIC_STEPS = 18;
    // products a*b are Q(2*FRAC_BITS); the dot product is kept in Q30
    localparam int DOT_LSHIFT   = 30 - 2 * FRAC_BITS;
    localparam int DOT_BITS     = 2 * COMP_BITS + DOT_LSHIFT + 2;

    localparam logic [BLEND_BITS-1:0] BLEND_ONE = BLEND_BITS'(65536);

    localparam longint ONE_Q30       = 64'sd1 << 30;
    localparam longint HALF_PI_Q30   = 64'sd1686629713;
    localparam longint PI_Q30        = 64'sd3373259426;
    localparam longint INV_GAIN_Q30  = 64'sd652032874;
    localparam longint SIN_FLOOR_Q30 = 64'sd1073742;
    // s < floor limit is the same as radicand < limit squared
    localparam logic [60:0] SIN_FLOOR_SQ = 61'(SIN_FLOOR_Q30 * SIN_FLOOR_Q30);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;

    typedef logic [1:0] path_t;
    localparam path_t PATH_COPY  = 2'd0;
    localparam path_t PATH_AVG   = 2'd1;
    localparam path_t PATH_BLEND = 2'd2;

    typedef logic signed [COMP_BITS-1:0] comp_t;
    typedef comp_t [3:0] quat_t;
    typedef logic [BLEND_BITS-1:0] blend_t;

    // one classified item between the front and the back
    typedef struct packed {
        quat_t              qa;
        quat_t              qb;
        blend_t             blend;
        path_t              path;
        logic signed [30:0] cos;
        logic [60:0]        rad;
    } entry_t;

    // atan(2^-k) in Q30, truncated
    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/qslerp_front.sv
// front: takes input beats, forms the dot product and picks the result path
module qslerp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  qslerp_pkg::quat_t   in_a,
    input  qslerp_pkg::quat_t   in_b,
    input  qslerp_pkg::blend_t  in_blend,
    output logic                out_valid,
    input  logic                out_ready,
    output qslerp_pkg::entry_t  out_entry
);
    import qslerp_pkg::*;

    logic [2:0] valid_reg;
    logic       adv;

    quat_t qa_reg [0:2];
    quat_t qb_reg [0:2];
    blend_t blend_reg [0:2];

    logic signed [2*COMP_BITS-1:0] prod_reg [0:3];
    logic signed [DOT_BITS-1:0]    dot_reg;
    logic [DOT_BITS-2:0]           mag_reg;
    logic signed [30:0]            cos_reg;
    logic                          big_reg;
    logic [59:0]                   sq_reg;

    logic signed [DOT_BITS-1:0] dot_sum;
    logic [DOT_BITS-2:0]        dot_mag;
    logic [60:0]                rad;

    assign adv      = !valid_reg[2] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_comb begin
        dot_sum = '0;
        for (int i = 0; i < 4; i++) begin
            dot_sum = dot_sum + (DOT_BITS'(prod_reg[i]) <<< DOT_LSHIFT);
        end
        dot_mag = dot_sum[DOT_BITS-1] ? (DOT_BITS-1)'(-dot_sum) : dot_sum[DOT_BITS-2:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1: blend clamp and component products
            qa_reg[0]    <= in_a;
            qb_reg[0]    <= in_b;
            blend_reg[0] <= (in_blend > BLEND_ONE) ? BLEND_ONE : in_blend;
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= $signed(in_a[i]) * $signed(in_b[i]);
            end
            // stage 2: dot product and its magnitude
            qa_reg[1]    <= qa_reg[0];
            qb_reg[1]    <= qb_reg[0];
            blend_reg[1] <= blend_reg[0];
            dot_reg      <= dot_sum;
            mag_reg      <= dot_mag;
            // stage 3: cosine, flag for |cos| >= 1 and square of the cosine
            qa_reg[2]    <= qa_reg[1];
            qb_reg[2]    <= qb_reg[1];
            blend_reg[2] <= blend_reg[1];
            cos_reg      <= dot_reg[30:0];
            big_reg      <= (mag_reg >= (DOT_BITS-1)'(ONE_Q30));
            sq_reg       <= mag_reg[29:0] * mag_reg[29:0];
        end
    end

    assign rad = (61'd1 << 60) - {1'b0, sq_reg};

    always_comb begin
        out_entry.qa    = qa_reg[2];
        out_entry.qb    = qb_reg[2];
        out_entry.blend = blend_reg[2];
        out_entry.cos   = cos_reg;
        out_entry.rad   = rad;
        priority if (big_reg) begin
            out_entry.path = PATH_COPY;
        end else if (rad < SIN_FLOOR_SQ) begin
            out_entry.path = PATH_AVG;
        end else begin
            out_entry.path = PATH_BLEND;
        end
    end

    assign out_valid = valid_reg[2];

endmodule

### hdl/qslerp_queue.sv
// short queue between the front and the back
module qslerp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  qslerp_pkg::entry_t  push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output qslerp_pkg::entry_t  pop_entry
);
    import qslerp_pkg::*;

    entry_t               slot_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   cnt_reg, cnt_next;
    logic                 push, pop;

    assign push_ready = (cnt_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QPTR_BITS+1)'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == cnt_reg[QPTR_BITS-1:0])
        else $error("queue pointers disagree with occupancy");
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && cnt_reg == '0) |=> pop_valid)
        else $error("pushed beat not visible");
`endif

endmodule

### hdl/qslerp_back.sv
// back: square root, acos and sin cordic, ratio division and blending pipeline
module qslerp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  qslerp_pkg::entry_t  in_entry,
    output logic                out_valid,
    input  logic                out_ready,
    output qslerp_pkg::quat_t   out_res,
    output qslerp_pkg::path_t   out_path
);
    import qslerp_pkg::*;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 42;
    localparam int AW        = 34;
    localparam int ST_ACOS   = SQ_STEPS;
    localparam int ST_ANG    = ST_ACOS + CORDIC_STEPS;
    localparam int ST_SIN    = ST_ANG + 1;
    localparam int ST_DIV    = ST_SIN + CORDIC_STEPS;
    localparam int ST_TERM   = ST_DIV + DIV_STEPS;
    localparam int ST_OUT    = ST_TERM + 1;
    localparam int N_ST      = ST_OUT + 1;
    localparam int TERM_BITS = COMP_BITS + 43 - 30;
    localparam int PROD_BITS = COMP_BITS + 43;

    typedef struct packed {
        quat_t              qa;
        quat_t              qb;
        blend_t             blend;
        path_t              path;
        logic signed [30:0] cos;
        logic [30:0]        sden;
    } carry_t;

    logic   valid_reg [0:N_ST-1];
    carry_t carry_reg [0:N_ST-1];
    carry_t carry_in  [0:N_ST-1];
    logic   adv;

    logic [63:0] sq_n_reg [0:SQ_STEPS-1];
    logic [63:0] sq_r_reg [0:SQ_STEPS-1];

    logic signed [AW-1:0] ac_x_reg [0:CORDIC_STEPS-1];
    logic signed [AW-1:0] ac_y_reg [0:CORDIC_STEPS-1];
    logic signed [AW-1:0] ac_z_reg [0:CORDIC_STEPS-1];

    logic [31:0] theta_reg, angb_reg;
    logic [31:0] theta_clamp;
    logic [48:0] ang_prod;

    logic signed [AW-1:0] sn_x_reg [0:CORDIC_STEPS-1][0:1];
    logic signed [AW-1:0] sn_y_reg [0:CORDIC_STEPS-1][0:1];
    logic signed [AW-1:0] sn_z_reg [0:CORDIC_STEPS-1][0:1];

    logic [31:0]          dv_rem_reg [0:DIV_STEPS-1][0:1];
    logic [DIV_STEPS-1:0] dv_lo_reg  [0:DIV_STEPS-1][0:1];
    logic [DIV_STEPS-1:0] dv_q_reg   [0:DIV_STEPS-1][0:1];
    logic                 dv_neg_reg [0:DIV_STEPS-1][0:1];

    logic signed [TERM_BITS-1:0] term_reg [0:1][0:3];
    logic signed [42:0]          ratio    [0:1];

    quat_t res_reg;
    path_t path_reg;

    assign adv      = !valid_reg[N_ST-1] || out_ready;
    assign in_ready = adv;

    // valid and per-item data that rides along every stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_ST; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < N_ST; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N_ST; i++) begin
            if (i == 0) begin
                carry_in[i].qa    = in_entry.qa;
                carry_in[i].qb    = in_entry.qb;
                carry_in[i].blend = in_entry.blend;
                carry_in[i].path  = in_entry.path;
                carry_in[i].cos   = in_entry.cos;
                carry_in[i].sden  = '0;
            end else begin
                carry_in[i] = carry_reg[i-1];
            end
            if (i == ST_ACOS) begin
                carry_in[i].sden = sq_r_reg[SQ_STEPS-1][30:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_ST; i++) begin
                carry_reg[i] <= carry_in[i];
            end
        end
    end

    // sine of the half angle: restoring square root, one result bit a stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_in, r_in, trial;
        if (k == 0) begin : g_first
            assign n_in = {3'b0, in_entry.rad};
            assign r_in = '0;
        end else begin : g_next
            assign n_in = sq_n_reg[k-1];
            assign r_in = sq_r_reg[k-1];
        end
        assign trial = r_in + SQ_BIT;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (n_in >= trial) begin
                    sq_n_reg[k] <= n_in - trial;
                    sq_r_reg[k] <= (r_in >> 1) + SQ_BIT;
                end else begin
                    sq_n_reg[k] <= n_in;
                    sq_r_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    // half angle: vectoring cordic on (cos, sin)
    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_acos
        localparam logic [4:0] K = 5'(j % 32);
        logic signed [AW-1:0] x_in, y_in, z_in, dx, dy, at;
        logic signed [30:0]   c;
        logic [30:0]          s;
        if (j == 0) begin : g_first
            assign c    = carry_reg[ST_ACOS-1].cos;
            assign s    = sq_r_reg[SQ_STEPS-1][30:0];
            assign x_in = c[30] ? AW'({1'b0, s}) : AW'(c);
            assign y_in = c[30] ? -AW'(c) : AW'({1'b0, s});
            assign z_in = c[30] ? AW'(HALF_PI_Q30) : '0;
        end else begin : g_next
            assign c    = '0;
            assign s    = '0;
            assign x_in = ac_x_reg[j-1];
            assign y_in = ac_y_reg[j-1];
            assign z_in = ac_z_reg[j-1];
        end
        assign dx = y_in >>> K;
        assign dy = x_in >>> K;
        assign at = AW'({1'b0, atan_q30(K)});
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (y_in > 0) begin
                    ac_x_reg[j] <= x_in + dx;
                    ac_y_reg[j] <= y_in - dy;
                    ac_z_reg[j] <= z_in + at;
                end else begin
                    ac_x_reg[j] <= x_in - dx;
                    ac_y_reg[j] <= y_in + dy;
                    ac_z_reg[j] <= z_in - at;
                end
            end
        end
    end

    // clamp the angle to [0, pi] and scale it by the blend factor
    always_comb begin
        priority if (ac_z_reg[CORDIC_STEPS-1] < 0) begin
            theta_clamp = '0;
        end else if (ac_z_reg[CORDIC_STEPS-1] > AW'(PI_Q30)) begin
            theta_clamp = 32'(PI_Q30);
        end else begin
            theta_clamp = ac_z_reg[CORDIC_STEPS-1][31:0];
        end
        ang_prod = theta_clamp * carry_reg[ST_ANG-1].blend;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            theta_reg <= theta_clamp;
            angb_reg  <= ang_prod[47:16];
        end
    end

    // two rotation cordics: channel 0 for (1-t)*theta, channel 1 for t*theta
    for (genvar ch = 0; ch < 2; ch++) begin : g_sin_ch
        for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_sin
            localparam logic [4:0] K = 5'(j % 32);
            logic signed [AW-1:0] x_in, y_in, z_in, dx, dy, at;
            logic [31:0]          ang, fold;
            if (j == 0) begin : g_first
                assign ang  = (ch == 0) ? theta_reg - angb_reg : angb_reg;
                assign fold = (ang > 32'(HALF_PI_Q30)) ? 32'(PI_Q30) - ang : ang;
                assign x_in = AW'(INV_GAIN_Q30);
                assign y_in = '0;
                assign z_in = AW'({1'b0, fold});
            end else begin : g_next
                assign ang  = '0;
                assign fold = '0;
                assign x_in = sn_x_reg[j-1][ch];
                assign y_in = sn_y_reg[j-1][ch];
                assign z_in = sn_z_reg[j-1][ch];
            end
            assign dx = y_in >>> K;
            assign dy = x_in >>> K;
            assign at = AW'({1'b0, atan_q30(K)});
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (z_in >= 0) begin
                        sn_x_reg[j][ch] <= x_in - dx;
                        sn_y_reg[j][ch] <= y_in + dy;
                        sn_z_reg[j][ch] <= z_in - at;
                    end else begin
                        sn_x_reg[j][ch] <= x_in + dx;
                        sn_y_reg[j][ch] <= y_in - dy;
                        sn_z_reg[j][ch] <= z_in + at;
                    end
                end
            end
        end

        // sin * 2^30 / s, restoring division on the magnitude, one bit a stage
        for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
            logic [31:0]          rem_in, trial;
            logic [DIV_STEPS-1:0] lo_in, q_in;
            logic                 neg_in;
            logic [AW-1:0]        mag;
            logic [30:0]          dsr;
            if (d == 0) begin : g_first
                assign neg_in = sn_y_reg[CORDIC_STEPS-1][ch][AW-1];
                assign mag    = neg_in ? AW'(-sn_y_reg[CORDIC_STEPS-1][ch])
                                       : sn_y_reg[CORDIC_STEPS-1][ch];
                assign rem_in = 32'(mag[AW-1:DIV_STEPS-30]);
                assign lo_in  = {mag[DIV_STEPS-31:0], 30'b0};
                assign q_in   = '0;
            end else begin : g_next
                assign neg_in = dv_neg_reg[d-1][ch];
                assign mag    = '0;
                assign rem_in = dv_rem_reg[d-1][ch];
                assign lo_in  = dv_lo_reg[d-1][ch];
                assign q_in   = dv_q_reg[d-1][ch];
            end
            assign dsr   = carry_reg[ST_DIV+d-1].sden;
            assign trial = {rem_in[30:0], lo_in[DIV_STEPS-1]};
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_neg_reg[d][ch] <= neg_in;
                    dv_lo_reg[d][ch]  <= lo_in << 1;
                    if (trial >= {1'b0, dsr}) begin
                        dv_rem_reg[d][ch] <= trial - {1'b0, dsr};
                        dv_q_reg[d][ch]   <= {q_in[DIV_STEPS-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[d][ch] <= trial;
                        dv_q_reg[d][ch]   <= {q_in[DIV_STEPS-2:0], 1'b0};
                    end
                end
            end
        end

        assign ratio[ch] = dv_neg_reg[DIV_STEPS-1][ch]
                         ? -$signed({1'b0, dv_q_reg[DIV_STEPS-1][ch]})
                         : $signed({1'b0, dv_q_reg[DIV_STEPS-1][ch]});
    end

    // weighted components, floored back to the component format
    // products are formed at full width so large ratios do not wrap
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                term_reg[0][i] <= TERM_BITS'(
                    (PROD_BITS'($signed(carry_reg[ST_TERM-1].qa[i]))
                     * PROD_BITS'(ratio[0])) >>> 30);
                term_reg[1][i] <= TERM_BITS'(
                    (PROD_BITS'($signed(carry_reg[ST_TERM-1].qb[i]))
                     * PROD_BITS'(ratio[1])) >>> 30);
            end
        end
    end

    // path select, saturation and the output register
    always_ff @(posedge aclk) begin
        logic signed [TERM_BITS:0]  sum;
        logic signed [COMP_BITS:0]  avg;
        if (adv) begin
            path_reg <= carry_reg[ST_OUT-1].path;
            for (int i = 0; i < 4; i++) begin
                sum = (TERM_BITS+1)'(term_reg[0][i]) + (TERM_BITS+1)'(term_reg[1][i]);
                avg = (COMP_BITS+1)'($signed(carry_reg[ST_OUT-1].qa[i]))
                    + (COMP_BITS+1)'($signed(carry_reg[ST_OUT-1].qb[i]));
                unique case (carry_reg[ST_OUT-1].path)
                    PATH_COPY: res_reg[i] <= carry_reg[ST_OUT-1].qa[i];
                    PATH_AVG:  res_reg[i] <= avg[COMP_BITS:1];
                    default: begin
                        priority if (sum > (TERM_BITS+1)'(2**(COMP_BITS-1) - 1)) begin
                            res_reg[i] <= {1'b0, {(COMP_BITS-1){1'b1}}};
                        end else if (sum < -(TERM_BITS+1)'(2**(COMP_BITS-1))) begin
                            res_reg[i] <= {1'b1, {(COMP_BITS-1){1'b0}}};
                        end else begin
                            res_reg[i] <= sum[COMP_BITS-1:0];
                        end
                    end
                endcase
            end
        end
    end

    assign out_valid = valid_reg[N_ST-1];
    assign out_res   = res_reg;
    assign out_path  = path_reg;

`ifndef SYNTH
    a_sden_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_DIV-1] && carry_reg[ST_DIV-1].path == PATH_BLEND)
        |-> (carry_reg[ST_DIV-1].sden >= 31'(SIN_FLOOR_Q30)))
        else $error("blend item with sine below floor");
    a_theta_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_ANG] |-> (angb_reg <= theta_reg))
        else $error("scaled angle exceeds full angle");
    a_out_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_OUT-1] && adv) |=> (path_reg == $past(carry_reg[ST_OUT-1].path)))
        else $error("result path lost its item");
`endif

endmodule

### hdl/quaternion_slerp_top.sv
// top level of the fixed-point quaternion slerp block
// Quaternion slerp: each beat on s_ carries two quaternions a and b (signed Q2.14)
// and a blend factor t (unsigned Q1.16, values above 1.0 are clamped), and gives
// exactly one beat on m_ with the interpolated quaternion and the path that was
// used (0 copied a for |a.b| >= 1, 1 averaged a and b for a tiny half-angle sine,
// 2 full spherical blend). The block takes one beat per clock cycle for as long
// as m_tready stays high. From the s_ handshake each beat passes the product, dot
// product and square registers of the front, then the queue, then the back with
// its 32-step square root, two 18-step cordics, angle register, 42-step ratio
// division and term and output registers. A stall on m_ holds the back; the
// two-beat queue keeps the front taking beats for a while longer.
module quaternion_slerp_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (16 bits each), blend (17 bits), zero pad
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_w, r_x, r_y, r_z (16 bits each)
    output logic [63:0]  m_tdata,
    // path_taken (2 bits)
    output logic [7:0]   m_tuser
);
    import qslerp_pkg::*;

    quat_t  in_a, in_b;
    blend_t in_blend;

    entry_t fr_entry, bk_entry;
    logic   fr_valid, fr_ready;
    logic   bk_valid, bk_ready;

    quat_t  res;
    path_t  res_path;

    // unpack the input beat, a_w in the lowest bits
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_a[i] = s_tdata[i*COMP_BITS +: COMP_BITS];
            in_b[i] = s_tdata[(4+i)*COMP_BITS +: COMP_BITS];
        end
        in_blend = s_tdata[8*COMP_BITS +: BLEND_BITS];
    end

    // dot product and path classification
    qslerp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_a      (in_a),
        .in_b      (in_b),
        .in_blend  (in_blend),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_entry (fr_entry)
    );

    // decouples the front from stalls in the back
    qslerp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_entry (fr_entry),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_entry  (bk_entry)
    );

    // angle, sines, ratios and the blended result
    qslerp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (bk_valid),
        .in_ready  (bk_ready),
        .in_entry  (bk_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_path  (res_path)
    );

    // pack the result beat, r_w in the lowest bits
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m_tdata[i*COMP_BITS +: COMP_BITS] = res[i];
        end
        m_tuser = {6'b0, res_path};
    end

endmodule

### tb/sv/quaternion_slerp_checker.sv
// checker for the quaternion slerp block: predicts each result beat and compares
module quaternion_slerp_checker
    import qslerp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [7:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [63:0] quat;
        logic [1:0]  path;
    } slerp_result_t;

    slerp_result_t interp_q[$];

    function automatic longint clamp_comp(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint half_angle(longint c, longint s);
        longint x, y, z, dx, dy;
        if (c >= 0) begin
            x = c; y = s; z = 0;
        end else begin
            x = s; y = -c; z = HALF_PI_Q30;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
            end
        end
        if (z < 0) z = 0;
        if (z > PI_Q30) z = PI_Q30;
        return z;
    endfunction

    function automatic longint sine_q30(longint ang);
        longint x, y, z, dx, dy;
        x = INV_GAIN_Q30;
        y = 0;
        if (ang > HALF_PI_Q30) ang = PI_Q30 - ang;
        z = ang;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
            end
        end
        return y;
    endfunction

    function automatic longint weigh(longint v, longint r);
        longint rh, rl;
        rh = r >>> 15;
        rl = r - rh * 32768;
        return (v * rh + ((v * rl) >>> 15)) >>> 15;
    endfunction

    function automatic slerp_result_t predict_slerp(logic [151:0] d);
        longint qa[4], qb[4], res[4];
        longint dot, mag, s, theta, ang_b, ang_a, ratio_a, ratio_b, t;
        slerp_result_t r;
        dot = 0;
        for (int i = 0; i < 4; i++) begin
            qa[i] = longint'($signed(d[16*i +: 16]));
            qb[i] = longint'($signed(d[64 + 16*i +: 16]));
            // Q28 products lifted to Q30
            dot += qa[i] * qb[i] * 4;
        end
        t = longint'(d[128 +: 17]);
        if (t > 65536) t = 65536;
        mag = dot < 0 ? -dot : dot;
        if (mag >= ONE_Q30) begin
            r.path = PATH_COPY;
            for (int i = 0; i < 4; i++) res[i] = qa[i];
        end else begin
            s = root_floor((64'sd1 << 60) - dot * dot);
            if (s < SIN_FLOOR_Q30) begin
                r.path = PATH_AVG;
                for (int i = 0; i < 4; i++) res[i] = (qa[i] + qb[i]) >>> 1;
            end else begin
                r.path = PATH_BLEND;
                theta = half_angle(dot, s);
                ang_b = (theta * t) >>> 16;
                ang_a = theta - ang_b;
                ratio_a = (sine_q30(ang_a) * ONE_Q30) / s;
                ratio_b = (sine_q30(ang_b) * ONE_Q30) / s;
                for (int i = 0; i < 4; i++)
                    res[i] = clamp_comp(weigh(qa[i], ratio_a) + weigh(qb[i], ratio_b));
            end
        end
        for (int i = 0; i < 4; i++) r.quat[16*i +: 16] = res[i][15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        slerp_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) interp_q.push_back(predict_slerp(s_tdata));
            if (m_tvalid && m_tready) begin
                if (interp_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = interp_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[16*i +: 16] !== want.quat[16*i +: 16])
                            report_mismatch($sformatf("component %0d got %h want %h",
                                i, m_tdata[16*i +: 16], want.quat[16*i +: 16]));
                    if (m_tuser[1:0] !== want.path)
                        report_mismatch($sformatf("path got %0d want %0d",
                            m_tuser[1:0], want.path));
                end
            end
        end
        // beats still owed by the block
        pending = interp_q.size();
    end

endmodule

### tb/sv/quaternion_slerp_top_tb.sv
// testbench top for the quaternion slerp block: stimulus, clock, reset and verdict
module quaternion_slerp_top_tb;
    import qslerp_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [7:0]   m_tuser;
    int           fail_count;
    int           pending;
    bit           stim_done = 1'b0;

    always #4 aclk = ~aclk;

    quaternion_slerp_top dut (.*);

    quaternion_slerp_checker chk (.*);

    // pack one request beat: a, b, then blend, zero pad on top
    function automatic logic [151:0] pack_req(logic [15:0] aw, logic [15:0] ax,
            logic [15:0] ay, logic [15:0] az, logic [15:0] bw, logic [15:0] bx,
            logic [15:0] by, logic [15:0] bz, logic [16:0] t);
        return {7'b0, t, bz, by, bx, bw, az, ay, ax, aw};
    endfunction

    // random component, mostly near unit scale so real blends dominate
    function automatic logic [15:0] rand_comp(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 16384)) - 8192);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // random blend: full range including values above one that get clamped
    function automatic logic [16:0] rand_blend();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // one beat, held until accepted; beats come in bursts with gaps between them
    int burst_left = 0;
    task automatic send_beat(logic [151:0] d);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // receiver stall pattern: long ready stretches, short and long stalls
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            m_tready <= 1'b0;
            repeat ($urandom_range(0, 2) == 0 ? $urandom_range(20, 150)
                                              : $urandom_range(1, 5)) @(posedge aclk);
        end
    end

    initial begin
        logic [15:0] q[8];
        int kind;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unit dot product: identical unit quaternions, and opposite ones
        send_beat(pack_req(16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 17'd32768));
        send_beat(pack_req(16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 17'd32768));
        // extremes of the components
        send_beat(pack_req(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                           16'h8000, 16'h8000, 16'h8000, 16'h8000, 17'd0));
        send_beat(pack_req(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'h8000, 16'h8000, 16'h8000, 16'h8000, 17'h1ffff));
        send_beat(pack_req(0, 0, 0, 0, 0, 0, 0, 0, 17'd0));
        // tiny sine: dot product just under one
        send_beat(pack_req(16'sd16384, 0, 0, 0, 16'sd16383, 16'sd1, 0, 0, 17'd100));
        send_beat(pack_req(16'sd16383, 0, 0, 0, 16'sd16384, 0, 0, 0, 17'd65536));
        // full blend at 90 degrees, with t = 0, half, one and above one
        send_beat(pack_req(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 17'd0));
        send_beat(pack_req(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 17'd32768));
        send_beat(pack_req(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 17'd65536));
        send_beat(pack_req(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 17'd70000));
        // theta near pi, where the ratios are large; then an oversized opposite pair on the copy path
        send_beat(pack_req(16'sd16384, 0, 0, 0, -16'sd16380, 16'sd300, 0, 0, 17'd32768));
        send_beat(pack_req(16'h7fff, 16'h7fff, 0, 0, 16'h8001, 16'h8001, 16'sd40, 0,
                           17'd40000));
        // small vectors with negative dot product
        send_beat(pack_req(16'sd100, -16'sd50, 16'sd7, 0, -16'sd90, 16'sd20, 0,
                           16'sd3, 17'd12345));

        for (int n = 0; n < 650; n++) begin
            kind = $urandom_range(0, 5);
            for (int i = 0; i < 8; i++) q[i] = rand_comp(kind > 2 ? 2 : kind);
            // some pairs near each other or opposite to hit the special paths
            if ($urandom_range(0, 7) == 0)
                for (int i = 0; i < 4; i++)
                    q[4+i] = q[i] + 16'($signed($urandom_range(0, 4)) - 2);
            else if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 4; i++) q[4+i] = -q[i];
            send_beat(pack_req(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7],
                               rand_blend()));
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge aclk);
        repeat (130) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS quaternion_slerp_top");
        end else begin
            $display("FAIL quaternion_slerp_top");
        end
        $finish;
    end

    // generous limit well past the slowest run with every stall
    initial begin
        #4000000;
        $display("FAIL quaternion_slerp_top");
        $finish;
    end

endmodule

### quaternion_slerp_top.f
hdl/qslerp_pkg.sv
hdl/qslerp_front.sv
hdl/qslerp_queue.sv
hdl/qslerp_back.sv
hdl/quaternion_slerp_top.sv
tb/sv/quaternion_slerp_checker.sv
tb/sv/quaternion_slerp_top_tb.sv
